// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms with reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rstn, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== sv/utf8r_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8r_pkg
// Types and constants shared by the UTF-8 decoder front end, queue and back end.
// ----------------------------------------------------------------------------
package utf8r_pkg;

	// Result queue geometry
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Decoder phase: which part of a multi-byte sequence is held
	typedef enum logic [1:0] {
		PH_IDLE      = 2'd0,
		PH_LEAD2     = 2'd1,
		PH_LEAD3     = 2'd2,
		PH_LEAD3_SEC = 2'd3
	} phase_t;

	// How a byte is handled when it starts fresh
	typedef enum logic [1:0] {
		FRESH_EMIT  = 2'd0,
		FRESH_HOLD2 = 2'd1,
		FRESH_HOLD3 = 2'd2
	} fresh_kind_t;

	// One queue entry: all output words caused by one input word.
	// Words go out as: raw lead (npre >= 1), raw second (npre == 2), then tail.
	typedef struct packed {
		logic [1:0]  cnt;
		logic [1:0]  npre;
		logic [7:0]  lead;
		logic [7:0]  second;
		logic [15:0] tail_cp;
		logic        tail_end;
	} entry_t;

endpackage

// ===== sv/utf8r_front.sv =====
// ----------------------------------------------------------------------------
// utf8r_front
// Accepts stream bytes, tracks the pending sequence and classifies each byte
// into at most one queue entry listing the words it causes.
// ----------------------------------------------------------------------------
module utf8r_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        in_byte,
	input  logic              stream_end,
	output logic              in_stall,
	output logic              q_push,
	output utf8r_pkg::entry_t q_data,
	input  logic              q_full
);
	import utf8r_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  held_lead_q;
	logic [7:0]  held_second_q;
	fresh_kind_t fresh_kind;
	phase_t      fresh_phase;
	logic        is_cont;
	logic        take;
	logic        fresh_go;
	logic        load_lead;
	logic        load_second;
	logic        has_tail;
	logic [1:0]  npre;
	logic [15:0] tail_cp;
	logic        tail_end;

	assign take     = in_valid && !q_full;
	assign in_stall = q_full;
	assign is_cont  = (in_byte[7:6] == 2'b10);

	// Classify a byte seen outside a sequence
	always_comb begin
		case (in_byte[7:4]) inside
			[4'h0:4'h7]: fresh_kind = FRESH_EMIT;
			4'hC, 4'hD:  fresh_kind = FRESH_HOLD2;
			4'hE:        fresh_kind = FRESH_HOLD3;
			default:     fresh_kind = FRESH_EMIT;
		endcase
	end

	always_comb begin
		case (fresh_kind)
			FRESH_HOLD2: fresh_phase = PH_LEAD2;
			FRESH_HOLD3: fresh_phase = PH_LEAD3;
			default:     fresh_phase = PH_IDLE;
		endcase
	end

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (stream_end) begin
			phase_d = PH_IDLE;
		end else begin
			case (phase_q)
				PH_IDLE:      phase_d = fresh_phase;
				PH_LEAD2:     phase_d = is_cont ? PH_IDLE : fresh_phase;
				PH_LEAD3:     phase_d = is_cont ? PH_LEAD3_SEC : fresh_phase;
				PH_LEAD3_SEC: phase_d = is_cont ? PH_IDLE : fresh_phase;
				default:      phase_d = PH_IDLE;
			endcase
		end
	end

	// Words caused by this byte
	always_comb begin
		npre        = 2'd0;
		has_tail    = 1'b0;
		tail_cp     = '0;
		tail_end    = 1'b0;
		fresh_go    = 1'b0;
		load_second = 1'b0;
		if (stream_end) begin
			// flush held bytes raw, then the end marker
			case (phase_q)
				PH_IDLE:      npre = 2'd0;
				PH_LEAD3_SEC: npre = 2'd2;
				default:      npre = 2'd1;
			endcase
			has_tail = 1'b1;
			tail_end = 1'b1;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					fresh_go = 1'b1;
				end
				PH_LEAD2: begin
					if (is_cont) begin
						has_tail = 1'b1;
						tail_cp  = {5'd0, held_lead_q[4:0], in_byte[5:0]};
					end else begin
						npre     = 2'd1;
						fresh_go = 1'b1;
					end
				end
				PH_LEAD3: begin
					if (is_cont) begin
						load_second = 1'b1;
					end else begin
						npre     = 2'd1;
						fresh_go = 1'b1;
					end
				end
				PH_LEAD3_SEC: begin
					if (is_cont) begin
						has_tail = 1'b1;
						tail_cp  = {held_lead_q[3:0], held_second_q[5:0], in_byte[5:0]};
					end else begin
						npre     = 2'd2;
						fresh_go = 1'b1;
					end
				end
				default: begin
					fresh_go = 1'b0;
				end
			endcase
			// broken or idle: the byte is decoded afresh
			if (fresh_go && fresh_kind == FRESH_EMIT) begin
				has_tail = 1'b1;
				tail_cp  = {8'd0, in_byte};
			end
		end
	end

	assign load_lead = fresh_go && (fresh_kind != FRESH_EMIT);

	// Queue entry
	always_comb begin
		q_data.cnt      = npre + {1'b0, has_tail};
		q_data.npre     = npre;
		q_data.lead     = held_lead_q;
		q_data.second   = held_second_q;
		q_data.tail_cp  = tail_cp;
		q_data.tail_end = tail_end;
	end

	assign q_push = take && (q_data.cnt != 2'd0);

	// Phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (take) begin
			phase_q <= phase_d;
		end
	end

	// Held bytes
	always_ff @(posedge clk) begin
		if (take && load_lead) begin
			held_lead_q <= in_byte;
		end
		if (take && load_second) begin
			held_second_q <= in_byte;
		end
	end

endmodule

// ===== sv/utf8r_fifo.sv =====
// ----------------------------------------------------------------------------
// utf8r_fifo
// Short register queue of decode entries between front end and back end.
// ----------------------------------------------------------------------------
module utf8r_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  utf8r_pkg::entry_t push_data,
	input  logic              pop,
	output utf8r_pkg::entry_t pop_data,
	output logic              full,
	output logic              empty
);
	import utf8r_pkg::*;

	entry_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full     = (count_q == QCNT_W'(QDEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/utf8r_back.sv =====
// ----------------------------------------------------------------------------
// utf8r_back
// Takes queue entries and sends their words out one per cycle while out_stall
// is low, marking the final word of each entry.
// ----------------------------------------------------------------------------
module utf8r_back (
	input  logic              clk,
	input  logic              arst_n,
	input  utf8r_pkg::entry_t q_data,
	input  logic              q_empty,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [15:0]       code_point,
	output logic              end_mark,
	output logic              last
);
	import utf8r_pkg::*;

	entry_t     cur_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       is_tail;
	logic       out_take;

	assign out_valid = busy_q;
	assign out_take  = busy_q && !out_stall;
	assign is_tail   = (idx_q >= cur_q.npre);
	assign last      = (idx_q == cur_q.cnt - 2'd1);

	// Word selection: raw lead, raw second, then tail
	always_comb begin
		if (is_tail) begin
			code_point = cur_q.tail_cp;
		end else if (idx_q == 2'd0) begin
			code_point = {8'd0, cur_q.lead};
		end else begin
			code_point = {8'd0, cur_q.second};
		end
		end_mark = is_tail && cur_q.tail_end;
	end

	// Load next entry when idle or as the final word leaves
	assign q_pop = !q_empty && (!busy_q || (out_take && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (out_take) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
	end

endmodule

// ===== sv/utf8_decoder_with_recovery.sv =====
// ----------------------------------------------------------------------------
// utf8_decoder_with_recovery: UTF-8 byte stream to 16-bit code points
// Path: a byte's first word passes the queue write, then the back-end load.
// Throughput: one byte per cycle while in_stall is low; a byte causes zero to
// three words, sent one at a time, and the queue soaks up the bursts.
// Reset: arst_n asynchronously clears phase, queue pointers and output valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8_decoder_with_recovery (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        stream_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] code_point,
	output logic        end_mark,
	output logic        last
);
	import utf8r_pkg::*;

	logic   q_push;
	logic   q_pop;
	logic   q_full;
	logic   q_empty;
	entry_t q_wdata;
	entry_t q_rdata;

	// Front end: sequence tracking and classification
	utf8r_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_byte    (in_byte),
		.stream_end (stream_end),
		.in_stall   (in_stall),
		.q_push     (q_push),
		.q_data     (q_wdata),
		.q_full     (q_full)
	);

	// Decoupling queue
	utf8r_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.full      (q_full),
		.empty     (q_empty)
	);

	// Back end: word serializer
	utf8r_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_data     (q_rdata),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_point (code_point),
		.end_mark   (end_mark),
		.last       (last)
	);

	// Checks
	`ASSERT_ALWAYS(a_no_push_full, clk, arst_n, !(q_push && q_full), "push into full queue")
	`ASSERT_ALWAYS(a_no_pop_empty, clk, arst_n, !(q_pop && q_empty), "pop from empty queue")
	`ASSERT_IMPLIES(a_end_word, clk, arst_n, out_valid && end_mark, (code_point == 16'd0) && last, "end marker must be zero and final")
	`ASSERT_IMPLIES(a_entry_cnt, clk, arst_n, q_push, q_wdata.cnt >= q_wdata.npre, "entry count below raw prefix")

endmodule
